### hw/rtl/hrte_pkg.sv
package hrte_pkg;

  // Shared serial divider geometry.
  localparam int unsigned DIV_DW = 48;
  localparam int unsigned DIV_VW = 24;

  // Logarithm result: 5 integer bits and 16 fraction bits.
  localparam int unsigned LOG_W = 21;

  // Configuration register indexes.
  localparam logic [1:0] REG_REF_RES   = 2'd0;
  localparam logic [1:0] REG_CABLE_RES = 2'd1;
  localparam logic [1:0] REG_INV_TCR   = 2'd2;

  // Reset values.
  localparam logic [23:0] REF_RES_RST  = 24'd32768;
  localparam logic [23:0] INV_TCR_RST  = 24'd42667;
  localparam logic [23:0] TEMP20_Q8    = 24'd5120;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ
  } log_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_PDIV,
    ST_PWAIT,
    ST_RDIV,
    ST_RWAIT,
    ST_RSUM,
    ST_RFWAIT,
    ST_ABS,
    ST_LOGR,
    ST_LOGRW,
    ST_LOGREF,
    ST_LOGREFW,
    ST_TMAG,
    ST_TTCR,
    ST_TSUM,
    ST_TDIV,
    ST_TWAIT,
    ST_DONE
  } est_state_t;

  // Start and completion of one operation on a shared iterative unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

### hw/rtl/hrte_div.sv
// Restoring divider, one quotient bit per cycle.
module hrte_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hrte_pkg::unit_req_t             req,
  input  logic [hrte_pkg::DIV_DW-1:0]     dividend,
  input  logic [hrte_pkg::DIV_VW-1:0]     divisor,
  output hrte_pkg::unit_rsp_t             rsp,
  output logic [hrte_pkg::DIV_DW-1:0]     quotient
);

  logic [hrte_pkg::DIV_DW-1:0] q_r;
  logic [hrte_pkg::DIV_VW-1:0] rem_r;
  logic [hrte_pkg::DIV_VW-1:0] dvs_r;
  logic [5:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [hrte_pkg::DIV_VW:0]   sh;
  logic                        ge;

  // One trial subtraction on the partial remainder.
  always_comb begin
    sh = {rem_r, q_r[hrte_pkg::DIV_DW-1]};
    ge = (sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(hrte_pkg::DIV_DW - 1);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? hrte_pkg::DIV_VW'(sh - {1'b0, dvs_r})
                    : sh[hrte_pkg::DIV_VW-1:0];
        q_r   <= {q_r[hrte_pkg::DIV_DW-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign quotient = q_r;

endmodule

### hw/rtl/hrte_log2.sv
// Iterative log2 with 16 fraction bits: a one-bit-per-cycle normalize,
// then one squaring of the mantissa per fraction bit.
module hrte_log2 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hrte_pkg::unit_req_t          req,
  input  logic [23:0]                  x,
  output hrte_pkg::unit_rsp_t          rsp,
  output logic [hrte_pkg::LOG_W-1:0]   result
);

  hrte_pkg::log_state_t state_r, state_nxt;
  logic [30:0] m_r;
  logic [4:0]  e_r;
  logic [15:0] frac_r;
  logic [3:0]  cnt_r;
  logic        done_r;
  logic [61:0] sq_full;
  logic [31:0] sq;

  // Square of the normalized mantissa, rescaled to 2^30 for one.
  always_comb begin
    sq_full = 62'(m_r) * 62'(m_r);
    sq      = sq_full[61:30];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrte_pkg::LG_IDLE: if (req.start) state_nxt = hrte_pkg::LG_NORM;
      hrte_pkg::LG_NORM: if (m_r[30]) state_nxt = hrte_pkg::LG_SQ;
      hrte_pkg::LG_SQ:   if (cnt_r == 4'd0) state_nxt = hrte_pkg::LG_IDLE;
      default:           state_nxt = hrte_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrte_pkg::LG_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == hrte_pkg::LG_SQ) && (cnt_r == 4'd0);
    end
  end

  // Mantissa, exponent and fraction registers.
  always_ff @(posedge clk) begin
    case (state_r)
      hrte_pkg::LG_IDLE: begin
        m_r   <= {x, 7'b0};
        e_r   <= 5'd23;
        cnt_r <= 4'd15;
      end
      hrte_pkg::LG_NORM: begin
        if (!m_r[30]) begin
          m_r <= {m_r[29:0], 1'b0};
          e_r <= e_r - 5'd1;
        end
      end
      hrte_pkg::LG_SQ: begin
        m_r    <= sq[31] ? sq[31:1] : sq[30:0];
        frac_r <= {frac_r[14:0], sq[31]};
        cnt_r  <= cnt_r - 4'd1;
      end
      default: begin
        m_r <= m_r;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign result   = {e_r, frac_r};

endmodule

### hw/rtl/heater_resistance_temperature_estimator.sv
// Heater resistance and temperature estimator. One result item follows
// each input item. Four passes of the bit-serial divider serve power
// scaling, voltage over current, the resistance smoothing and the
// temperature smoothing. Each of the two logarithms normalizes its input
// with up to 23 shifts. A resistance sum below zero skips the resistance
// divide, and a zero resistance skips both logarithms. A new item is
// taken once the previous one has left the sequencer. The result register
// lets a finished item wait for the sink. While the sink holds off a
// second finished item waits in the sequencer, and the input stalls.
// Configuration writes are accepted in every cycle.
module heater_resistance_temperature_estimator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] voltage_sample, [29:16] current_sample, [31:30] zero
  input  logic [31:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] avg_voltage, [29:16] avg_current, [50:30] avg_power,
  // [74:51] heater_resistance, [98:75] heater_temperature, [103:99] zero
  output logic [103:0] out_tdata,
  // [0] no_heater
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  hrte_pkg::est_state_t state_r, state_nxt;

  logic [23:0] ref_res_r, cable_res_r, inv_tcr_r;
  logic [23:0] vf_r;
  logic [21:0] cf_r;
  logic [31:0] pf_r;
  logic [23:0] rf_r;
  logic signed [23:0] tf_r;
  logic [45:0] prod_r;
  logic [23:0] meas_r;
  logic        absent_r;
  logic [hrte_pkg::LOG_W-1:0] lr_r;
  logic signed [22:0] d_r;
  logic        neg_r;
  logic [21:0] lnm_r;
  logic [30:0] tm_r;
  logic signed [35:0] ts_r;

  logic        out_valid_r;
  logic [103:0] out_data_r;
  logic        out_user_r;

  hrte_pkg::unit_req_t div_req, log_req;
  hrte_pkg::unit_rsp_t div_rsp, log_rsp;
  logic [hrte_pkg::DIV_DW-1:0] div_dividend, div_q;
  logic [hrte_pkg::DIV_VW-1:0] div_divisor;
  logic [23:0] log_x;
  logic [hrte_pkg::LOG_W-1:0] log_res;

  logic [21:0] c_clamp;
  logic [28:0] rs_pos, rs_sub;
  logic        rs_neg;
  logic        absent;
  logic [23:0] rf_eff;
  logic [23:0] r20;
  logic signed [22:0] d_raw;
  logic [20:0] mag;
  logic signed [32:0] tgt;
  logic [35:0] ts_abs;
  logic        out_free;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_res_r   <= hrte_pkg::REF_RES_RST;
      cable_res_r <= '0;
      inv_tcr_r   <= hrte_pkg::INV_TCR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        hrte_pkg::REG_REF_RES:   ref_res_r   <= cfg_data;
        hrte_pkg::REG_CABLE_RES: cable_res_r <= cfg_data;
        hrte_pkg::REG_INV_TCR:   inv_tcr_r   <= cfg_data;
        default:                 ref_res_r   <= ref_res_r;
      endcase
    end
  end

  // Combinational helpers for the sequencer steps.
  always_comb begin
    if (cf_r < 22'd256) c_clamp = 22'd256;
    else if (cf_r > 22'd3840000) c_clamp = 22'd3840000;
    else c_clamp = cf_r;
    rs_pos  = 29'(rf_r) * 29'd7 + 29'(meas_r) * 29'd3;
    rs_sub  = 29'(cable_res_r) * 29'd3;
    rs_neg  = rs_pos < rs_sub;
    absent  = (vf_r > 24'd25600) && (cf_r < 22'd2560);
    rf_eff  = absent ? ref_res_r : rf_r;
    r20     = (ref_res_r == '0) ? 24'd1 : ref_res_r;
    d_raw   = $signed({2'b0, lr_r}) - $signed({2'b0, log_res});
    mag     = d_r[22] ? 21'(-d_r) : 21'(d_r);
    tgt     = (neg_r ? -$signed({2'b0, tm_r}) : $signed({2'b0, tm_r}))
              + 33'sd5120;
    ts_abs  = ts_r[35] ? 36'(-ts_r) : 36'(ts_r);
    out_free = !out_valid_r || out_tready;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrte_pkg::ST_IDLE:    if (in_tvalid) state_nxt = hrte_pkg::ST_MUL;
      hrte_pkg::ST_MUL:     state_nxt = hrte_pkg::ST_PDIV;
      hrte_pkg::ST_PDIV:    state_nxt = hrte_pkg::ST_PWAIT;
      hrte_pkg::ST_PWAIT:   if (div_rsp.done) state_nxt = hrte_pkg::ST_RDIV;
      hrte_pkg::ST_RDIV:    state_nxt = hrte_pkg::ST_RWAIT;
      hrte_pkg::ST_RWAIT:   if (div_rsp.done) state_nxt = hrte_pkg::ST_RSUM;
      hrte_pkg::ST_RSUM:    state_nxt = rs_neg ? hrte_pkg::ST_ABS : hrte_pkg::ST_RFWAIT;
      hrte_pkg::ST_RFWAIT:  if (div_rsp.done) state_nxt = hrte_pkg::ST_ABS;
      hrte_pkg::ST_ABS:     state_nxt = (rf_eff == '0) ? hrte_pkg::ST_TMAG
                                                       : hrte_pkg::ST_LOGR;
      hrte_pkg::ST_LOGR:    state_nxt = hrte_pkg::ST_LOGRW;
      hrte_pkg::ST_LOGRW:   if (log_rsp.done) state_nxt = hrte_pkg::ST_LOGREF;
      hrte_pkg::ST_LOGREF:  state_nxt = hrte_pkg::ST_LOGREFW;
      hrte_pkg::ST_LOGREFW: if (log_rsp.done) state_nxt = hrte_pkg::ST_TMAG;
      hrte_pkg::ST_TMAG:    state_nxt = hrte_pkg::ST_TTCR;
      hrte_pkg::ST_TTCR:    state_nxt = hrte_pkg::ST_TSUM;
      hrte_pkg::ST_TSUM:    state_nxt = hrte_pkg::ST_TDIV;
      hrte_pkg::ST_TDIV:    state_nxt = hrte_pkg::ST_TWAIT;
      hrte_pkg::ST_TWAIT:   if (div_rsp.done) state_nxt = hrte_pkg::ST_DONE;
      hrte_pkg::ST_DONE:    if (out_free) state_nxt = hrte_pkg::ST_IDLE;
      default:              state_nxt = hrte_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and operands of the shared units.
  always_comb begin
    in_tready     = (state_r == hrte_pkg::ST_IDLE);
    div_req.start = 1'b0;
    log_req.start = 1'b0;
    div_dividend  = '0;
    div_divisor   = 24'd1;
    log_x         = rf_r;
    case (state_r)
      hrte_pkg::ST_PDIV: begin
        div_req.start = 1'b1;
        div_dividend  = 48'(prod_r);
        div_divisor   = 24'd64000;
      end
      hrte_pkg::ST_RDIV: begin
        div_req.start = 1'b1;
        div_dividend  = {8'b0, vf_r, 16'b0};
        div_divisor   = 24'(c_clamp);
      end
      hrte_pkg::ST_RSUM: begin
        div_req.start = !rs_neg;
        div_dividend  = 48'(rs_pos - rs_sub) + 48'd5;
        div_divisor   = 24'd10;
      end
      hrte_pkg::ST_TDIV: begin
        div_req.start = 1'b1;
        div_dividend  = 48'(ts_abs) + 48'd5;
        div_divisor   = 24'd10;
      end
      hrte_pkg::ST_LOGR: begin
        log_req.start = 1'b1;
      end
      hrte_pkg::ST_LOGREF: begin
        log_req.start = 1'b1;
        log_x         = r20;
      end
      default: begin
        log_x = rf_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hrte_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
      cf_r <= '0;
      pf_r <= '0;
      rf_r <= hrte_pkg::REF_RES_RST;
      tf_r <= $signed(hrte_pkg::TEMP20_Q8);
    end else begin
      case (state_r)
        hrte_pkg::ST_IDLE: if (in_tvalid) begin
          vf_r <= 24'((25'(vf_r) + {1'b0, in_tdata[15:0], 8'b0}) >> 1);
          cf_r <= 22'((23'(cf_r) + {1'b0, in_tdata[29:16], 8'b0}) >> 1);
        end
        hrte_pkg::ST_PWAIT: if (div_rsp.done) begin
          pf_r <= 32'((33'(pf_r) + 33'(div_q[31:0])) >> 1);
        end
        hrte_pkg::ST_RSUM: if (rs_neg) begin
          rf_r <= '0;
        end
        hrte_pkg::ST_RFWAIT: if (div_rsp.done) begin
          rf_r <= (|div_q[47:24]) ? 24'hFFFFFF : div_q[23:0];
        end
        hrte_pkg::ST_ABS: begin
          rf_r <= rf_eff;
        end
        hrte_pkg::ST_TWAIT: if (div_rsp.done) begin
          if (!neg_r && div_q > 48'd8388607) tf_r <= 24'sd8388607;
          else if (neg_r && div_q > 48'd8388608) tf_r <= -24'sd8388608;
          else if (neg_r) tf_r <= -$signed(div_q[23:0]);
          else tf_r <= $signed(div_q[23:0]);
        end
        default: begin
          vf_r <= vf_r;
        end
      endcase
    end
  end

  // Intermediate values of the current item.
  always_ff @(posedge clk) begin
    case (state_r)
      hrte_pkg::ST_MUL:   prod_r <= 46'(vf_r) * 46'(cf_r);
      hrte_pkg::ST_RWAIT: if (div_rsp.done) begin
        meas_r <= (|div_q[47:24]) ? 24'hFFFFFF : div_q[23:0];
      end
      hrte_pkg::ST_ABS: begin
        absent_r <= absent;
        d_r      <= -23'sd1048576;
      end
      hrte_pkg::ST_LOGRW: if (log_rsp.done) lr_r <= log_res;
      hrte_pkg::ST_LOGREFW: if (log_rsp.done) begin
        d_r <= (d_raw < -23'sd1048576) ? -23'sd1048576 : d_raw;
      end
      hrte_pkg::ST_TMAG: begin
        neg_r <= d_r[22];
        lnm_r <= 22'((38'(mag) * 38'd45426 + 38'd32768) >> 16);
      end
      hrte_pkg::ST_TTCR: begin
        tm_r <= 31'((47'(lnm_r) * 47'(inv_tcr_r) + 47'd32768) >> 16);
      end
      hrte_pkg::ST_TSUM: begin
        ts_r  <= 36'($signed({{12{tf_r[23]}}, tf_r})) * 36'sd7
                 + 36'($signed({{3{tgt[32]}}, tgt})) * 36'sd3;
      end
      hrte_pkg::ST_TDIV: neg_r <= ts_r[35];
      default: prod_r <= prod_r;
    endcase
  end

  // Result register; a finished item waits here for the sink.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == hrte_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hrte_pkg::ST_DONE && out_free) begin
      out_data_r <= {5'b0, tf_r, rf_r, pf_r[30:10], cf_r[21:8], vf_r[23:8]};
      out_user_r <= absent_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

  hrte_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp),
    .quotient (div_q)
  );

  hrte_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (log_req),
    .x      (log_x),
    .rsp    (log_rsp),
    .result (log_res)
  );

endmodule

### sim/heater_resistance_temperature_estimator_tb.sv
module heater_resistance_temperature_estimator_tb;

  localparam int unsigned DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [15:0] avg_voltage;
    logic [13:0] avg_current;
    logic [20:0] avg_power;
    logic [23:0] heater_resistance;
    logic [23:0] heater_temperature;
    logic        no_heater;
  } estimate_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_data;

  heater_resistance_temperature_estimator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor copy of the configuration and filter state.
  logic [23:0] pr_ref_res;
  logic [23:0] pr_cable_res;
  logic [23:0] pr_inv_tcr;
  logic [23:0] pr_volt_filt;
  logic [23:0] pr_curr_filt;
  logic [31:0] pr_pow_filt;
  logic [23:0] pr_res_filt;
  longint      pr_temp_filt;

  estimate_t expected_estimates[$];
  int  mismatch_count;
  bit  timed_out;
  bit  idle_enable;
  bit  sink_hold;
  int  idle_pct;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // log2 with 16 fraction bits by repeated squaring of the mantissa.
  function automatic longint log2_frac16(input logic [23:0] x);
    int          e;
    logic [23:0] t;
    logic [63:0] m;
    longint      frac;
    e = 0;
    t = x;
    frac = 0;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    m = 64'(x) << (30 - e);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (longint'(1) << i);
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  // Advance the predicted filters by one sample pair.
  function automatic estimate_t estimate_sample(input logic [15:0] vs,
                                                input logic [13:0] cs);
    estimate_t   r;
    logic [63:0] prod;
    logic [63:0] cl;
    logic [63:0] meas;
    longint      s;
    longint      d;
    longint      mag;
    longint      lnm;
    longint      tm;
    longint      term;
    logic [23:0] r20;
    bit          absent;
    pr_volt_filt = 24'((25'(pr_volt_filt) + (25'(vs) << 8)) >> 1);
    pr_curr_filt = 24'((25'(pr_curr_filt) + (25'(cs) << 8)) >> 1);
    prod = 64'(pr_volt_filt) * 64'(pr_curr_filt) / 64'd64000;
    pr_pow_filt = 32'((64'(pr_pow_filt) + prod) >> 1);
    cl = 64'(pr_curr_filt);
    if (cl < 256) cl = 256;
    if (cl > 64'd3840000) cl = 64'd3840000;
    meas = (64'(pr_volt_filt) << 16) / cl;
    if (meas > 64'hFFFFFF) meas = 64'hFFFFFF;
    s = 7 * longint'(pr_res_filt)
        + 3 * (longint'(meas) - longint'(pr_cable_res));
    if (s < 0) s = 0;
    else begin
      s = (s + 5) / 10;
      if (s > 64'hFFFFFF) s = 64'hFFFFFF;
    end
    pr_res_filt = 24'(s);
    absent = (pr_volt_filt > 25600) && (pr_curr_filt < 2560);
    if (absent) pr_res_filt = pr_ref_res;
    r20 = (pr_ref_res == 0) ? 24'd1 : pr_ref_res;
    if (pr_res_filt == 0) d = -16 * 65536;
    else begin
      d = log2_frac16(pr_res_filt) - log2_frac16(r20);
      if (d < -16 * 65536) d = -16 * 65536;
    end
    mag = (d < 0) ? -d : d;
    lnm = (mag * 45426 + 32768) >>> 16;
    tm = (lnm * longint'(pr_inv_tcr) + 32768) >>> 16;
    term = (d < 0) ? -tm : tm;
    s = 7 * pr_temp_filt + 3 * (term + 5120);
    s = (s < 0) ? -((-s + 5) / 10) : (s + 5) / 10;
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    pr_temp_filt = s;
    r.avg_voltage = pr_volt_filt[23:8];
    r.avg_current = pr_curr_filt[21:8];
    r.avg_power = pr_pow_filt[30:10];
    r.heater_resistance = pr_res_filt;
    r.heater_temperature = 24'(s);
    r.no_heater = absent;
    return r;
  endfunction

  function automatic bit idle_roll();
    return idle_enable && ($urandom_range(99) < idle_pct);
  endfunction

  // Send one sample pair; the prediction is made when it is accepted.
  task automatic send_sample(input logic [15:0] vs, input logic [13:0] cs);
    while (idle_roll()) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, cs, vs};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_estimates.push_back(estimate_sample(vs, cs));
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_estimates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hrte_pkg::REG_REF_RES: pr_ref_res = val;
      hrte_pkg::REG_CABLE_RES: pr_cable_res = val;
      default: pr_inv_tcr = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    estimate_t got;
    estimate_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[29:16], out_tdata[50:30], out_tdata[74:51],
             out_tdata[98:75], out_tuser[0]};
      if (expected_estimates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result item %h", got);
      end else begin
        exp_r = expected_estimates.pop_front();
        if (got !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected v=%0d i=%0d p=%0d r=%0d t=%0d nh=%0d,",
                     exp_r.avg_voltage, exp_r.avg_current, exp_r.avg_power,
                     exp_r.heater_resistance, $signed(exp_r.heater_temperature),
                     exp_r.no_heater,
                     " got v=%0d i=%0d p=%0d r=%0d t=%0d nh=%0d",
                     got.avg_voltage, got.avg_current, got.avg_power,
                     got.heater_resistance, $signed(got.heater_temperature),
                     got.no_heater);
        end
      end
    end
  end

  // Sink readiness: random stalls, or a long hold-off when requested.
  always @(negedge clk) begin
    if (sink_hold) out_tready <= 1'b0;
    else out_tready <= !idle_roll();
  end

  task automatic test_field_extremes();
    send_sample(16'd0, 14'd0);
    send_sample(16'hFFFF, 14'h3FFF);
    send_sample(16'hFFFF, 14'd0);
    send_sample(16'hFFFF, 14'd0);
    send_sample(16'd0, 14'h3FFF);
    send_sample(16'd0, 14'h3FFF);
    send_sample(16'h5555, 14'h2AAA);
    send_sample(16'hAAAA, 14'h1555);
    send_sample(16'd60000, 14'd15000);
    wait_drained();
  endtask

  // Heater missing: high voltage with tiny current, then recovery.
  task automatic test_absent_heater();
    repeat (4) send_sample(16'd5000, 14'd2);
    send_sample(16'd101, 14'd9);
    repeat (3) send_sample(16'd12000, 14'd1000);
    wait_drained();
  endtask

  // Resistance driven to zero by a large lead resistance, and an extreme ratio.
  task automatic test_resistance_floor();
    write_reg(hrte_pkg::REG_CABLE_RES, 24'hFFFFFF);
    write_reg(hrte_pkg::REG_INV_TCR, 24'hFFFFFF);
    repeat (4) send_sample(16'd1000, 14'd5000);
    wait_drained();
    write_reg(hrte_pkg::REG_REF_RES, 24'd0);
    write_reg(hrte_pkg::REG_CABLE_RES, 24'd0);
    write_reg(hrte_pkg::REG_INV_TCR, 24'd1);
    repeat (3) send_sample(16'd5000, 14'd3);
    send_sample(16'hFFFF, 14'd1);
    wait_drained();
    write_reg(hrte_pkg::REG_REF_RES, 24'hFFFFFF);
    repeat (3) send_sample(16'd100, 14'd16000);
    wait_drained();
  endtask

  task automatic random_phase(input int count, input int pct, input bit en);
    logic [15:0] vs;
    logic [13:0] cs;
    idle_pct = pct;
    idle_enable = en;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(5))
        0: begin vs = 16'($urandom); cs = 14'($urandom); end
        1: begin vs = 16'($urandom_range(65535, 200)); cs = 14'($urandom_range(9)); end
        2: begin vs = 16'($urandom_range(500)); cs = 14'($urandom_range(16383, 14000)); end
        default: begin
          vs = 16'($urandom_range(24000, 1000));
          cs = 14'($urandom_range(4000, 200));
        end
      endcase
      send_sample(vs, cs);
    end
    idle_enable = 1'b1;
    idle_pct = 29;
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(hrte_pkg::REG_REF_RES, 24'($urandom_range(24'hFFFFFF, 1)));
      write_reg(hrte_pkg::REG_CABLE_RES,
                (ph == 0) ? 24'd0 : 24'($urandom_range(300000)));
      write_reg(hrte_pkg::REG_INV_TCR, 24'($urandom_range(24'hFFFFFF, 1)));
      random_phase(140, 29, 1'b1);
      wait_drained();
    end
    write_reg(hrte_pkg::REG_REF_RES, hrte_pkg::REF_RES_RST);
    write_reg(hrte_pkg::REG_CABLE_RES, 24'd3000);
    write_reg(hrte_pkg::REG_INV_TCR, hrte_pkg::INV_TCR_RST);
    random_phase(300, 0, 1'b0);
    random_phase(250, 29, 1'b1);
  endtask

  // Sink holds off while the source keeps offering items.
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (2000) @(negedge clk);
        sink_hold = 1'b0;
      end
      random_phase(12, 0, 1'b0);
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = hrte_pkg::REG_REF_RES;
    cfg_data = '0;
    mismatch_count = 0;
    timed_out = 1'b0;
    idle_enable = 1'b1;
    idle_pct = 29;
    sink_hold = 1'b0;
    pr_ref_res = hrte_pkg::REF_RES_RST;
    pr_cable_res = 24'd0;
    pr_inv_tcr = hrte_pkg::INV_TCR_RST;
    pr_volt_filt = '0;
    pr_curr_filt = '0;
    pr_pow_filt = '0;
    pr_res_filt = hrte_pkg::REF_RES_RST;
    pr_temp_filt = 5120;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_field_extremes();
    test_absent_heater();
    test_resistance_floor();
    test_random_settings();
    test_backpressure();
    wait_drained();
    if (mismatch_count == 0 && !timed_out) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20000000;
    timed_out = 1'b1;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
